// ----- hw/rtl/adps_pkg.sv -----
// Shared types, constants, mask tables and the square-root step for the disc pixel shader.
package adps_pkg;

	// Matrix geometry: serpentine chain of panels stacked in rows.
	localparam int PANEL_COLS  = 32;
	localparam int PANEL_ROWS  = 8;
	localparam int PANEL_COUNT = 3;
	localparam int CANVAS_COLS = 36;
	localparam int CANVAS_ROWS = 28;
	localparam int LED_COUNT   = PANEL_COLS * PANEL_ROWS * PANEL_COUNT;

	// Occlusion mask store.
	localparam int MASK_COLS = 36;
	localparam int MASK_ROWS = 28;
	localparam int MCOL_W    = $clog2(MASK_COLS);
	localparam int MROW_W    = $clog2(MASK_ROWS);

	// Field widths.
	localparam int COORD_W  = 6;
	localparam int CENTER_W = 14;
	localparam int COLOR_W  = 24;
	localparam int RADIUS_W = 10;
	localparam int INDEX_W  = 10;
	localparam int CHAN_W   = 8;

	// Distance arithmetic: squares of 14-bit magnitudes, and a square root that is only
	// needed below 2^20 because the radius never exceeds 1023 in Q2.8.
	localparam int MAG_W       = 14;
	localparam int SQ_W        = 2 * MAG_W;
	localparam int D2_W        = SQ_W + 1;
	localparam int RAD_W       = 2 * RADIUS_W;
	localparam int REM_W       = RADIUS_W + 1;
	localparam int SQRT_ITERS  = 2;
	localparam int SQRT_STAGES = RADIUS_W / SQRT_ITERS;

	// Register indexes of the configuration port.
	typedef enum logic [2:0] {
		REG_SUN_RGB     = 3'd0,
		REG_MOON_RGB    = 3'd1,
		REG_SUN_RAD     = 3'd2,
		REG_MOON_RAD    = 3'd3,
		REG_COL_ORIGIN  = 3'd4,
		REG_ROW_ORIGIN  = 3'd5,
		REG_MASK_ENABLE = 3'd6,
		REG_PANEL_FLIP  = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		logic [COLOR_W-1:0]  sun_rgb;
		logic [COLOR_W-1:0]  moon_rgb;
		logic [RADIUS_W-1:0] sun_rad;
		logic [RADIUS_W-1:0] moon_rad;
		logic [COORD_W-1:0]  col_origin;
		logic [COORD_W-1:0]  row_origin;
		logic [2:0]          mask_enable;
		logic [2:0]          panel_flip;
	} cfg_t;

	// Request handed from the front end to the square-root pipeline.
	typedef struct packed {
		logic [RAD_W-1:0]   rad;
		logic [INDEX_W-1:0] led;
		logic               sel;
	} dsq_t;

	// Request handed from the square-root pipeline to the shading stages.
	typedef struct packed {
		logic [RADIUS_W-1:0] dist_q8;
		logic [INDEX_W-1:0]  led;
		logic                sel;
	} dist_t;

	// Working state of the digit-by-digit square root.
	typedef struct packed {
		logic [RAD_W-1:0]    rad;
		logic [REM_W-1:0]    rem;
		logic [RADIUS_W-1:0] root;
	} sq_t;

	// Bit x of row y set means that pixel is occluded.
	localparam logic [MASK_COLS-1:0] FRONT_ROWS [MASK_ROWS] = '{
		36'h0031ffe00, 36'h01f07fc00, 36'h0000001c0, 36'h000001fff, 36'h0000000ff,
		36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0,
		36'h000000030, 36'h000003fff, 36'h000007fff, 36'h00001ffe0, 36'h000008000,
		36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0
	};

	localparam logic [MASK_COLS-1:0] BACK_ROWS [MASK_ROWS] = '{
		36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0,
		36'h0, 36'h0, 36'h0,
		36'h000180000, 36'h0087e0000, 36'h03ffe8000, 36'h01c7e0000, 36'h000661bf0,
		36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0
	};

	localparam logic [MASK_COLS-1:0] HORIZON_ROWS [MASK_ROWS] = '{
		36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0,
		36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0, 36'h0,
		36'h000006000, 36'h000007000, 36'h00002fc00,
		36'hfffffffff, 36'hfffffffff, 36'hfffffffff, 36'hfffffffff,
		36'hfffffffff, 36'hfffffffff, 36'hfffffffff, 36'hfffffffff
	};

	// One restoring step: brings down the next two radicand bits and settles one root bit.
	function automatic sq_t sqrt_iter(sq_t a);
		logic [REM_W+1:0] r;
		logic [REM_W+1:0] t;
		sq_t              res;
		r        = {a.rem, a.rad[RAD_W-1 -: 2]};
		t        = {1'b0, a.root, 2'b01};
		res.rad  = {a.rad[RAD_W-3:0], 2'b00};
		if (r >= t) begin
			res.rem  = REM_W'(r - t);
			res.root = {a.root[RADIUS_W-2:0], 1'b1};
		end else begin
			res.rem  = r[REM_W-1:0];
			res.root = {a.root[RADIUS_W-2:0], 1'b0};
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/adps_front.sv -----
// Front end: painting and mask culling, offsets, squares, LED chain position.
module adps_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  adps_pkg::cfg_t                    cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [adps_pkg::COORD_W-1:0]      pixel_x,
	input  logic [adps_pkg::COORD_W-1:0]      pixel_y,
	input  logic [adps_pkg::CENTER_W-1:0]     center_col,
	input  logic [adps_pkg::CENTER_W-1:0]     center_row,
	input  logic                              body_select,
	output logic                              out_valid,
	input  logic                              out_ready,
	output adps_pkg::dsq_t                    out_req
);

	logic                              keep_in;
	logic signed [adps_pkg::CENTER_W+1:0] dx, dy;
	logic [adps_pkg::MAG_W-1:0]        adx, ady;

	logic                              v_s1, v_s2, v_s3;
	logic                              rdy1, rdy2, rdy3;
	logic [adps_pkg::COORD_W-1:0]      x_s1, y_s1;
	logic                              sel_s1, sel_s2;
	logic [adps_pkg::MAG_W-1:0]        adx_s1, ady_s1;
	logic [adps_pkg::SQ_W-1:0]         sqx_s2, sqy_s2;
	logic [adps_pkg::INDEX_W-1:0]      led_s2;
	adps_pkg::dsq_t                    req_s3;

	logic signed [adps_pkg::COORD_W:0] mx, my;
	logic                              in_matrix;
	logic [adps_pkg::COORD_W-1:0]      my_u, panel, ly, lx, row;
	logic                              flip;
	logic [adps_pkg::INDEX_W-1:0]      led_idx;
	logic [adps_pkg::D2_W-1:0]         d2;

	// Culling on the incoming request; masks outside the store never occlude.
	always_comb begin
		logic hit_f, hit_b, hit_h;
		hit_f = 1'b0;
		hit_b = 1'b0;
		hit_h = 1'b0;
		if (pixel_x < adps_pkg::MASK_COLS && pixel_y < adps_pkg::MASK_ROWS) begin
			hit_f = adps_pkg::FRONT_ROWS[pixel_y[adps_pkg::MROW_W-1:0]]
				[pixel_x[adps_pkg::MCOL_W-1:0]];
			hit_b = adps_pkg::BACK_ROWS[pixel_y[adps_pkg::MROW_W-1:0]]
				[pixel_x[adps_pkg::MCOL_W-1:0]];
			hit_h = adps_pkg::HORIZON_ROWS[pixel_y[adps_pkg::MROW_W-1:0]]
				[pixel_x[adps_pkg::MCOL_W-1:0]];
		end
		keep_in = pixel_x < adps_pkg::CANVAS_COLS && pixel_y < adps_pkg::CANVAS_ROWS
			&& !(cfg.mask_enable[0] && hit_f)
			&& !(cfg.mask_enable[1] && hit_b)
			&& !(cfg.mask_enable[2] && hit_h);
	end

	assign dx  = signed'({2'b00, pixel_x, 8'h00}) - signed'({2'b00, center_col});
	assign dy  = signed'({2'b00, pixel_y, 8'h00}) - signed'({2'b00, center_row});
	assign adx = dx[adps_pkg::CENTER_W+1] ? adps_pkg::MAG_W'(-dx) : dx[adps_pkg::MAG_W-1:0];
	assign ady = dy[adps_pkg::CENTER_W+1] ? adps_pkg::MAG_W'(-dy) : dy[adps_pkg::MAG_W-1:0];

	// Serpentine position: odd columns run upwards, flipped panels are mirrored both ways.
	always_comb begin
		mx        = signed'({1'b0, x_s1}) - signed'({1'b0, cfg.col_origin});
		my        = signed'({1'b0, y_s1}) - signed'({1'b0, cfg.row_origin});
		in_matrix = mx >= 0 && mx < adps_pkg::PANEL_COLS && my >= 0
			&& my < adps_pkg::PANEL_ROWS * adps_pkg::PANEL_COUNT;
		my_u      = my[adps_pkg::COORD_W-1:0];
		panel     = adps_pkg::COORD_W'(my_u / adps_pkg::PANEL_ROWS);
		ly        = adps_pkg::COORD_W'(my_u % adps_pkg::PANEL_ROWS);
		lx        = mx[adps_pkg::COORD_W-1:0];
		flip      = panel < 3 && cfg.panel_flip[panel[1:0]];
		if (flip) begin
			lx = adps_pkg::COORD_W'(adps_pkg::PANEL_COLS - 1) - lx;
			ly = adps_pkg::COORD_W'(adps_pkg::PANEL_ROWS - 1) - ly;
		end
		row       = lx[0] ? adps_pkg::COORD_W'(adps_pkg::PANEL_ROWS - 1) - ly : ly;
		led_idx   = adps_pkg::INDEX_W'(lx * adps_pkg::PANEL_ROWS)
			+ adps_pkg::INDEX_W'(row)
			+ adps_pkg::INDEX_W'(panel * (adps_pkg::PANEL_COLS * adps_pkg::PANEL_ROWS));
	end

	assign d2 = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid && keep_in;
			if (rdy2) v_s2 <= v_s1 && in_matrix;
			if (rdy3) v_s3 <= v_s2 && d2[adps_pkg::D2_W-1:adps_pkg::RAD_W] == '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			x_s1   <= pixel_x;
			y_s1   <= pixel_y;
			sel_s1 <= body_select;
			adx_s1 <= adx;
			ady_s1 <= ady;
		end
		if (rdy2) begin
			sqx_s2 <= adx_s1 * adx_s1;
			sqy_s2 <= ady_s1 * ady_s1;
			led_s2 <= led_idx;
			sel_s2 <= sel_s1;
		end
		if (rdy3) begin
			req_s3.rad <= d2[adps_pkg::RAD_W-1:0];
			req_s3.led <= led_s2;
			req_s3.sel <= sel_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_req   = req_s3;

endmodule

// ----- hw/rtl/adps_isqrt.sv -----
// Pipelined integer square root, two result bits per stage.
module adps_isqrt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  adps_pkg::dsq_t in_req,
	output logic           out_valid,
	input  logic           out_ready,
	output adps_pkg::dist_t out_req
);

	adps_pkg::sq_t                    sq_s  [adps_pkg::SQRT_STAGES];
	logic [adps_pkg::INDEX_W-1:0]     led_s [adps_pkg::SQRT_STAGES];
	logic                             sel_s [adps_pkg::SQRT_STAGES];
	logic [adps_pkg::SQRT_STAGES-1:0] v_s;
	logic [adps_pkg::SQRT_STAGES:0]   rdy;
	adps_pkg::sq_t                    nxt   [adps_pkg::SQRT_STAGES];

	always_comb begin
		rdy[adps_pkg::SQRT_STAGES] = out_ready;
		for (int k = adps_pkg::SQRT_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end

	always_comb begin
		nxt[0].rad  = in_req.rad;
		nxt[0].rem  = '0;
		nxt[0].root = '0;
		for (int k = 1; k < adps_pkg::SQRT_STAGES; k++) begin
			nxt[k] = sq_s[k-1];
		end
		for (int k = 0; k < adps_pkg::SQRT_STAGES; k++) begin
			for (int i = 0; i < adps_pkg::SQRT_ITERS; i++) begin
				nxt[k] = adps_pkg::sqrt_iter(nxt[k]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			for (int k = 1; k < adps_pkg::SQRT_STAGES; k++) begin
				if (rdy[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			sq_s[0]  <= nxt[0];
			led_s[0] <= in_req.led;
			sel_s[0] <= in_req.sel;
		end
		for (int k = 1; k < adps_pkg::SQRT_STAGES; k++) begin
			if (rdy[k]) begin
				sq_s[k]  <= nxt[k];
				led_s[k] <= led_s[k-1];
				sel_s[k] <= sel_s[k-1];
			end
		end
	end

	assign in_ready        = rdy[0];
	assign out_valid       = v_s[adps_pkg::SQRT_STAGES-1];
	assign out_req.dist_q8 = sq_s[adps_pkg::SQRT_STAGES-1].root;
	assign out_req.led     = led_s[adps_pkg::SQRT_STAGES-1];
	assign out_req.sel     = sel_s[adps_pkg::SQRT_STAGES-1];

endmodule

// ----- hw/rtl/adps_shade.sv -----
// Edge coverage from the distance, then colour scaling into the output register.
module adps_shade (
	input  logic                          clk,
	input  logic                          arst_n,
	input  adps_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  adps_pkg::dist_t               in_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [adps_pkg::INDEX_W-1:0]  led_index,
	output logic [adps_pkg::CHAN_W-1:0]   red,
	output logic [adps_pkg::CHAN_W-1:0]   green,
	output logic [adps_pkg::CHAN_W-1:0]   blue
);

	logic [adps_pkg::RADIUS_W-1:0] radius, diff;
	logic                          lit;
	logic [8:0]                    alpha;
	logic [16:0]                   prod;
	logic [adps_pkg::COLOR_W-1:0]  color;
	logic [8:0]                    gain;
	logic [16:0]                   mr, mg, mb;

	logic                          v_s9, v_s10, rdy9, rdy10;
	logic [adps_pkg::CHAN_W-1:0]   s_s9;
	logic [adps_pkg::INDEX_W-1:0]  led_s9, led_s10;
	logic                          sel_s9;
	logic [adps_pkg::CHAN_W-1:0]   red_s10, green_s10, blue_s10;

	// Coverage ramps over a quarter pixel inside the rim and saturates at one.
	always_comb begin
		radius = in_req.sel ? cfg.moon_rad : cfg.sun_rad;
		lit    = in_req.dist_q8 < radius;
		diff   = radius - in_req.dist_q8;
		alpha  = (diff >= adps_pkg::RADIUS_W'(64)) ? 9'd256 : {1'b0, diff[5:0], 2'b00};
		prod   = {alpha, 8'h00} - 17'(alpha) + 17'd128;
	end

	always_comb begin
		color = sel_s9 ? cfg.moon_rgb : cfg.sun_rgb;
		gain  = {1'b0, s_s9} + 9'd1;
		mr    = color[23:16] * gain;
		mg    = color[15:8] * gain;
		mb    = color[7:0] * gain;
	end

	assign rdy10    = !v_s10 || out_ready;
	assign rdy9     = !v_s9 || rdy10;
	assign in_ready = rdy9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			if (rdy9) v_s9 <= in_valid && lit;
			if (rdy10) v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy9) begin
			s_s9   <= prod[15:8];
			led_s9 <= in_req.led;
			sel_s9 <= in_req.sel;
		end
		if (rdy10) begin
			led_s10   <= led_s9;
			red_s10   <= mr[15:8];
			green_s10 <= mg[15:8];
			blue_s10  <= mb[15:8];
		end
	end

	assign out_valid = v_s10;
	assign led_index = led_s10;
	assign red       = red_s10;
	assign green     = green_s10;
	assign blue      = blue_s10;

endmodule

// ----- hw/rtl/antialiased_disc_pixel_shader.sv -----
// Top level of the anti-aliased disc pixel shader: configuration registers and pipeline.
//
// Pixel requests arrive on pix_valid/pix_ready with painting coordinates, the body
// centre in Q6.8 and the sun/moon select. Each request yields at most one result on
// led_valid/led_ready: the chain position of the LED and the scaled colour. Pixels
// outside the painting, under an enabled mask, outside the disc or off the matrix
// give nothing and simply leave a bubble behind.
// The pipeline is ten register stages deep: three for culling, offsets, squares and
// the chain position, five for the square root (two root bits per stage) and two
// for coverage and colour scaling. A lit pixel is presented once its request has
// passed through every stage; one request is taken every cycle while led_ready
// does not stall the pipeline.
// Every stage holds its own valid bit, so when led_ready is low the pipeline keeps
// accepting requests until its stages fill up; nothing is lost or repeated.
// Configuration writes on cfg_valid/cfg_ready are always accepted and
// should be made while no request is in flight.
// Reset clears every valid bit and loads the default colours, radii, origin, mask
// enables and panel flips.
module antialiased_disc_pixel_shader (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [adps_pkg::COLOR_W-1:0]      cfg_data,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  logic [adps_pkg::COORD_W-1:0]      pixel_x,
	input  logic [adps_pkg::COORD_W-1:0]      pixel_y,
	input  logic [adps_pkg::CENTER_W-1:0]     center_col,
	input  logic [adps_pkg::CENTER_W-1:0]     center_row,
	input  logic                              body_select,
	output logic                              led_valid,
	input  logic                              led_ready,
	output logic [adps_pkg::INDEX_W-1:0]      led_index,
	output logic [adps_pkg::CHAN_W-1:0]       red,
	output logic [adps_pkg::CHAN_W-1:0]       green,
	output logic [adps_pkg::CHAN_W-1:0]       blue
);

	adps_pkg::cfg_t  cfg_q;
	logic            fr_valid, fr_ready, sq_valid, sq_ready;
	adps_pkg::dsq_t  fr_req;
	adps_pkg::dist_t sq_req;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sun_rgb     <= 24'd16766528;
			cfg_q.moon_rgb    <= 24'd12505855;
			cfg_q.sun_rad     <= 10'd512;
			cfg_q.moon_rad    <= 10'd256;
			cfg_q.col_origin  <= 6'd2;
			cfg_q.row_origin  <= 6'd0;
			cfg_q.mask_enable <= 3'd7;
			cfg_q.panel_flip  <= 3'd5;
		end else if (cfg_valid) begin
			case (adps_pkg::cfg_reg_e'(cfg_index))
				adps_pkg::REG_SUN_RGB:     cfg_q.sun_rgb     <= cfg_data;
				adps_pkg::REG_MOON_RGB:    cfg_q.moon_rgb    <= cfg_data;
				adps_pkg::REG_SUN_RAD:     cfg_q.sun_rad     <= cfg_data[9:0];
				adps_pkg::REG_MOON_RAD:    cfg_q.moon_rad    <= cfg_data[9:0];
				adps_pkg::REG_COL_ORIGIN:  cfg_q.col_origin  <= cfg_data[5:0];
				adps_pkg::REG_ROW_ORIGIN:  cfg_q.row_origin  <= cfg_data[5:0];
				adps_pkg::REG_MASK_ENABLE: cfg_q.mask_enable <= cfg_data[2:0];
				adps_pkg::REG_PANEL_FLIP:  cfg_q.panel_flip  <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	adps_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (pix_valid),
		.in_ready    (pix_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.center_col  (center_col),
		.center_row  (center_row),
		.body_select (body_select),
		.out_valid   (fr_valid),
		.out_ready   (fr_ready),
		.out_req     (fr_req)
	);

	adps_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_req    (fr_req),
		.out_valid (sq_valid),
		.out_ready (sq_ready),
		.out_req   (sq_req)
	);

	adps_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (sq_valid),
		.in_ready  (sq_ready),
		.in_req    (sq_req),
		.out_valid (led_valid),
		.out_ready (led_ready),
		.led_index (led_index),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

// ----- hw/rtl/adps_checker.sv -----
// Port-level checks for the disc pixel shader, bound to the top level.
module adps_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic                             pix_valid,
	input logic                             pix_ready,
	input logic                             led_valid,
	input logic                             led_ready,
	input logic [adps_pkg::INDEX_W-1:0]     led_index,
	input logic [adps_pkg::CHAN_W-1:0]      red,
	input logic [adps_pkg::CHAN_W-1:0]      green,
	input logic [adps_pkg::CHAN_W-1:0]      blue
);

	// When the receiver takes results, every stage can move, so a new request fits.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		led_ready |-> pix_ready)
		else $error("pixel request refused although the result side is ready");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid && !led_ready |=> led_valid && $stable(led_index) && $stable(red)
			&& $stable(green) && $stable(blue))
		else $error("stalled result changed or vanished");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		led_valid |-> led_index < adps_pkg::INDEX_W'(adps_pkg::LED_COUNT))
		else $error("LED index beyond the end of the chain");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write was held off");

endmodule

bind antialiased_disc_pixel_shader adps_checker u_adps_checker (.*);
